// ===== sv/kipc_pkg.sv =====
// ----------------------------------------------------------------------------
// kipc_pkg: shared types and constants
// Types, constants and control structs used by the controller, the datapath,
// the top level and the testbench of the k-inversion permutation counter.
// ----------------------------------------------------------------------------
package kipc_pkg;

	localparam int IN_W = 10;
	localparam int DW   = 30;
	localparam logic [DW-1:0] MODULUS = 30'd1000000007;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ROW,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_FINAL,
		ST_WAIT
	} kipc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic issue;
		logic col_inc;
		logic row_inc;
		logic flip;
		logic fin_issue;
	} kipc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic col_last;
		logic row_last;
		logic no_rows;
		logic fin_done;
	} kipc_stat_t;

endpackage

// ===== sv/k_inverse_pair_permutation_count.sv =====
// ----------------------------------------------------------------------------
// k_inverse_pair_permutation_count: Mahonian number modulo 1000000007
// A word (length_n, inversions_k) is taken when start is high and busy is
// low. Length and count saturate to MAX_N and MAX_K. The block builds the
// prefix-sum rows 1..n over columns 0..k, one column per cycle through a
// memory with two read ports and one write port, and then returns the count
// of permutations of 1..n with exactly k inversions. The result appears on
// count_mod for exactly one cycle with done high; each row sweeps columns
// 0..k and is followed by ST_DRAIN1 and ST_DRAIN2 so that the write-back
// pipeline drains before the next row reads it. The receiver cannot stall:
// it must capture the result in the cycle done is high.
// ----------------------------------------------------------------------------
module k_inverse_pair_permutation_count #(
	parameter int MAX_N = 1023,
	parameter int MAX_K = 1023
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [kipc_pkg::IN_W-1:0]     length_n,
	input  logic [kipc_pkg::IN_W-1:0]     inversions_k,
	output logic                          done,
	output logic [kipc_pkg::DW-1:0]       count_mod
);
	import kipc_pkg::*;

	kipc_cmd_t  cmd;
	kipc_stat_t stat;

	kipc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	kipc_dp #(
		.MAX_N (MAX_N),
		.MAX_K (MAX_K)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.length_n     (length_n),
		.inversions_k (inversions_k),
		.done         (done),
		.count_mod    (count_mod)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word shown while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("job ended without a result word");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> count_mod < MODULUS)
		else $error("result word not reduced");

endmodule

// ===== sv/kipc_ctrl.sv =====
// ----------------------------------------------------------------------------
// kipc_ctrl: sequencer
// Walks the rows and columns of the prefix-sum table, inserts the drain
// cycles between rows and launches the final difference.
// ----------------------------------------------------------------------------
module kipc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  kipc_pkg::kipc_stat_t   stat,
	output kipc_pkg::kipc_cmd_t    cmd
);
	import kipc_pkg::*;

	kipc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = stat.no_rows ? ST_FINAL : ST_ROW;
			end
			ST_ROW: begin
				if (stat.col_last) state_d = ST_DRAIN1;
			end
			ST_DRAIN1: begin
				state_d = ST_DRAIN2;
			end
			ST_DRAIN2: begin
				state_d = stat.row_last ? ST_FINAL : ST_ROW;
			end
			ST_FINAL: begin
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (stat.fin_done) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_SETUP: begin
			end
			ST_ROW: begin
				cmd.issue   = 1'b1;
				cmd.col_inc = 1'b1;
			end
			ST_DRAIN1: begin
			end
			ST_DRAIN2: begin
				// The last write of the row lands at this edge, so the banks swap here.
				cmd.flip    = 1'b1;
				cmd.row_inc = !stat.row_last;
			end
			ST_FINAL: begin
				cmd.fin_issue = 1'b1;
			end
			ST_WAIT: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/kipc_dp.sv =====
// ----------------------------------------------------------------------------
// kipc_dp: row stores and modular arithmetic
// Holds the ping-pong prefix-sum rows in one two-read memory, the row and
// column counters, and a short pipeline that forms each new prefix sum.
// ----------------------------------------------------------------------------
module kipc_dp #(
	parameter int MAX_N = 1023,
	parameter int MAX_K = 1023
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kipc_pkg::kipc_cmd_t           cmd,
	output kipc_pkg::kipc_stat_t          stat,
	input  logic [kipc_pkg::IN_W-1:0]     length_n,
	input  logic [kipc_pkg::IN_W-1:0]     inversions_k,
	output logic                          done,
	output logic [kipc_pkg::DW-1:0]       count_mod
);
	import kipc_pkg::*;

	localparam int NW    = $clog2(MAX_N + 1);
	localparam int KW    = $clog2(MAX_K + 1);
	localparam int AW    = KW + 1;
	// The bank bit sits above the column, so each bank spans a full power of two.
	localparam int DEPTH = 2 ** AW;

	logic [NW-1:0] n_q, i_q;
	logic [KW-1:0] k_q, j_q;
	logic          bank_q;
	logic [DW-1:0] cur_q;

	logic [DW-1:0] mem [DEPTH];
	logic [AW-1:0] rd_a_addr, rd_b_addr, wr_addr;

	// Stage 1: read data and flags of the issued column.
	logic          valid_s1, fin_s1, col0_s1, azero_s1, bzero_s1;
	logic [KW-1:0] col_s1;
	logic [DW-1:0] rd_a_s1, rd_b_s1;
	// Stage 2: difference of the previous row, ready to accumulate.
	logic          valid_s2, fin_s2, col0_s2;
	logic [KW-1:0] col_s2;
	logic [DW-1:0] f_s2;

	logic          done_q;
	logic [DW-1:0] count_q;

	logic          azero_d, bzero_d, col0_d;
	logic [DW-1:0] a_val, b_val, f_d;
	logic [DW:0]   sum_w;
	logic [DW-1:0] sum_mod, wr_val;
	logic [NW-1:0] n_sat;
	logic [KW-1:0] k_sat;

	always_comb begin
		if (32'(length_n) > 32'(MAX_N)) n_sat = NW'(MAX_N);
		else n_sat = NW'(length_n);
		if (32'(inversions_k) > 32'(MAX_K)) k_sat = KW'(MAX_K);
		else k_sat = KW'(inversions_k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			k_q    <= '0;
			i_q    <= '0;
			j_q    <= '0;
			bank_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				n_q <= n_sat;
				k_q <= k_sat;
				i_q <= NW'(1);
				j_q <= '0;
			end else begin
				if (cmd.col_inc) j_q <= j_q + KW'(1);
				if (cmd.row_inc) begin
					i_q <= i_q + NW'(1);
					j_q <= '0;
				end
			end
			if (cmd.flip) bank_q <= ~bank_q;
		end
	end

	assign stat.col_last = (j_q == k_q);
	assign stat.row_last = (i_q == n_q);
	assign stat.no_rows  = (n_q == '0);
	assign stat.fin_done = fin_s2;

	// bank_q selects the row being written; the other bank holds the previous row.
	// Row 1 reads its predecessor as all zeros, which stands in for row 0.
	always_comb begin
		if (cmd.fin_issue) begin
			rd_a_addr = {~bank_q, k_q};
			rd_b_addr = {~bank_q, k_q - KW'(1)};
			azero_d   = (n_q == '0);
			bzero_d   = (n_q == '0);
			col0_d    = 1'b0;
		end else begin
			rd_a_addr = {~bank_q, j_q};
			rd_b_addr = {~bank_q, KW'(32'(j_q) - 32'(i_q))};
			azero_d   = (i_q == NW'(1));
			bzero_d   = (i_q == NW'(1)) || (32'(j_q) < 32'(i_q));
			col0_d    = (j_q == '0);
		end
	end

	assign wr_addr = {bank_q, col_s2};

	always_ff @(posedge clk) begin
		rd_a_s1 <= mem[rd_a_addr];
		rd_b_s1 <= mem[rd_b_addr];
		if (valid_s2 && !fin_s2) mem[wr_addr] <= wr_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fin_s1   <= 1'b0;
			valid_s2 <= 1'b0;
			fin_s2   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue || cmd.fin_issue;
			fin_s1   <= cmd.fin_issue;
			valid_s2 <= valid_s1;
			fin_s2   <= fin_s1;
			done_q   <= fin_s2;
		end
	end

	always_ff @(posedge clk) begin
		col_s1   <= j_q;
		col0_s1  <= col0_d;
		azero_s1 <= azero_d;
		bzero_s1 <= bzero_d;
		col_s2   <= col_s1;
		col0_s2  <= col0_s1;
		f_s2     <= f_d;
	end

	// Modular difference of the two previous-row prefix sums.
	always_comb begin
		a_val = azero_s1 ? '0 : rd_a_s1;
		b_val = bzero_s1 ? '0 : rd_b_s1;
		if (a_val >= b_val) f_d = a_val - b_val;
		else f_d = a_val + (MODULUS - b_val);
	end

	// Running prefix sum of the current row.
	always_comb begin
		sum_w = {1'b0, cur_q} + {1'b0, f_s2};
		if (sum_w >= {1'b0, MODULUS}) sum_mod = DW'(sum_w - {1'b0, MODULUS});
		else sum_mod = DW'(sum_w);
		wr_val = col0_s2 ? DW'(1) : sum_mod;
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && !fin_s2) cur_q <= wr_val;
		if (fin_s2) count_q <= (k_q == '0) ? DW'(1) : f_s2;
	end

	assign done      = done_q;
	assign count_mod = count_q;

endmodule

// ===== verif/k_inverse_pair_permutation_count_tb.sv =====
// ----------------------------------------------------------------------------
// k_inverse_pair_permutation_count_tb: self-checking bench for the counter
// Sends directed and then random (length_n, inversions_k) words through the
// start/busy handshake, the random ones in bursts, and checks every count_mod strobe against a row-by-row
// prefix-sum computation of the Mahonian number modulo 1000000007.
// ----------------------------------------------------------------------------
module k_inverse_pair_permutation_count_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import kipc_pkg::*;

	localparam int MAX_N = 1023;
	localparam int MAX_K = 1023;
	localparam longint unsigned PRIME = MODULUS;

	typedef struct {
		bit [IN_W-1:0] n;
		bit [IN_W-1:0] k;
		bit [DW-1:0]   count;
	} pending_count_t;

	class mahonian_scoreboard;
		bit [DW-1:0] prior_row [0:MAX_K];
		bit [DW-1:0] work_row [0:MAX_K];
		pending_count_t awaiting [$];
		int mismatches;
		int unexpected;
		int counts_checked;

		function new();
			foreach (prior_row[j]) begin
				prior_row[j] = '0;
				work_row[j] = '0;
			end
			mismatches = 0;
			unexpected = 0;
			counts_checked = 0;
		endfunction

		function bit [DW-1:0] mod_minus(bit [DW-1:0] a, bit [DW-1:0] b);
			longint unsigned d;
			d = longint'(a) + PRIME - longint'(b);
			return DW'(d % PRIME);
		endfunction

		function bit [DW-1:0] mod_plus(bit [DW-1:0] a, bit [DW-1:0] b);
			longint unsigned s;
			s = longint'(a) + longint'(b);
			return DW'(s % PRIME);
		endfunction

		// Row i holds prefix sums over columns 0..k; each row is derived from
		// the one before by a windowed difference of width i.
		function bit [DW-1:0] mahonian(int n, int k);
			bit [DW-1:0] term;
			if (n > MAX_N) n = MAX_N;
			if (k > MAX_K) k = MAX_K;
			for (int j = 0; j <= k; j++) prior_row[j] = '0;
			for (int i = 1; i <= n; i++) begin
				work_row[0] = 1;
				for (int j = 1; j <= k; j++) begin
					term = prior_row[j];
					if (j >= i) term = mod_minus(term, prior_row[j-i]);
					work_row[j] = mod_plus(work_row[j-1], term);
				end
				for (int j = 0; j <= k; j++) prior_row[j] = work_row[j];
			end
			if (k == 0) return 1;
			return mod_minus(prior_row[k], prior_row[k-1]);
		endfunction

		function void note_word(bit [IN_W-1:0] n, bit [IN_W-1:0] k);
			pending_count_t item;
			item.n = n;
			item.k = k;
			item.count = mahonian(n, k);
			awaiting.push_back(item);
		endfunction

		function int failures();
			return mismatches + unexpected;
		endfunction

		function int pending();
			return awaiting.size();
		endfunction

		function void check_count(bit [DW-1:0] got);
			pending_count_t want;
			if (awaiting.size() == 0) begin
				unexpected++;
				if (failures() <= 10)
					$display("%0t: done strobe with no word outstanding, count_mod=%0d",
						$realtime, got);
				return;
			end
			want = awaiting.pop_front();
			counts_checked++;
			if (got !== want.count) begin
				mismatches++;
				if (failures() <= 10)
					$display("%0t: n=%0d k=%0d count_mod expected %0d, got %0d",
						$realtime, want.n, want.k, want.count, got);
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic [IN_W-1:0] length_n;
	logic [IN_W-1:0] inversions_k;
	logic            done;
	logic [DW-1:0]   count_mod;

	mahonian_scoreboard sb;
	int words_taken;
	int drain_pauses;
	int widest_n;
	int widest_k;

	k_inverse_pair_permutation_count #(
		.MAX_N(MAX_N),
		.MAX_K(MAX_K)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.length_n(length_n),
		.inversions_k(inversions_k),
		.done(done),
		.count_mod(count_mod)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check_count(count_mod);
	end

	// Start stays high across a burst; only the fields change between words.
	task automatic send_word(int n, int k);
		@(negedge clk);
		start <= 1'b1;
		length_n <= IN_W'(n);
		inversions_k <= IN_W'(k);
		do @(posedge clk); while (busy);
		sb.note_word(IN_W'(n), IN_W'(k));
		words_taken++;
		if (n > widest_n) widest_n = n;
		if (k > widest_k) widest_k = k;
	endtask

	// Fields wander while start is low; the block must ignore them.
	task automatic idle_gap(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
			length_n <= IN_W'($urandom);
			inversions_k <= IN_W'($urandom);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		drain_pauses++;
	endtask

	task automatic random_word();
		int n;
		int k;
		case ($urandom_range(0, 9))
			0: begin
				n = $urandom_range(0, MAX_N);
				k = $urandom_range(0, 15);
			end
			1: begin
				n = $urandom_range(0, 7);
				k = $urandom_range(0, MAX_K);
			end
			default: begin
				n = $urandom_range(0, 40);
				k = $urandom_range(0, 80);
			end
		endcase
		send_word(n, k);
	endtask

	initial begin
		int directed_n [] = '{0, 0, 0, 1, 1, 2, 2, 3, 4, 5, 5, 6, 6, 10, 20, 20,
			100, 1023, 1023, 1023, 1, 3, 7, 1023};
		int directed_k [] = '{0, 1, 1023, 0, 1, 0, 1, 3, 6, 10, 11, 15, 16, 5, 190, 191,
			37, 0, 1, 20, 1023, 1023, 1023, 1023};
		int burst_left;

		sb = new();
		words_taken = 0;
		drain_pauses = 0;
		widest_n = 0;
		widest_k = 0;
		arst_n = 1'b0;
		start = 1'b0;
		length_n = '0;
		inversions_k = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_n[i]) begin
			send_word(directed_n[i], directed_k[i]);
			if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 4));
		end
		wait_drained();

		burst_left = 0;
		for (int w = 0; w < 100; w++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 8);
				if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
			end
			random_word();
			burst_left--;
			if (w % 25 == 24) wait_drained();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Checked %0d counts from %0d words, n up to %0d and k up to %0d.",
			sb.counts_checked, words_taken, widest_n, widest_k);
		$display("Sender emptied the pipeline %0d times; %0d counts were wrong or stray.",
			drain_pauses, sb.failures());
		if (sb.failures() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timed out with %0d counts outstanding.", sb.pending());
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
sv/kipc_pkg.sv
sv/kipc_ctrl.sv
sv/kipc_dp.sv
sv/k_inverse_pair_permutation_count.sv
verif/k_inverse_pair_permutation_count_tb.sv
